@@ design/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the touch slide to stick block.
// ----------------------------------------------------------------------------
package tss_pkg;

	// direction code, two's complement: +1, -1 or neutral
	typedef logic [1:0] dir_t;

	localparam dir_t DIR_NEUTRAL = 2'd0;
	localparam dir_t DIR_POS     = 2'd1;
	localparam dir_t DIR_NEG     = 2'd3;

	// register index on the configuration port
	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_ENABLED      = 3'd0;
	localparam reg_idx_t REG_ZONE_SPLIT_X = 3'd1;
	localparam reg_idx_t REG_DEADZONE     = 3'd2;
	localparam reg_idx_t REG_REV_MIN_STEP = 3'd3;
	localparam reg_idx_t REG_FULL_SCALE   = 3'd4;

	// register reset values
	localparam logic        RST_ENABLED      = 1'b1;
	localparam logic [10:0] RST_ZONE_SPLIT_X = 11'd640;
	localparam logic [9:0]  RST_DEADZONE     = 10'd12;
	localparam logic [9:0]  RST_REV_MIN_STEP = 10'd10;
	localparam logic [14:0] RST_FULL_SCALE   = 15'd32767;

endpackage

@@ design/touch_slide_to_stick_core.sv @@
// ----------------------------------------------------------------------------
// touch_slide_to_stick_core
// Tracks slides in a left and a right screen zone and turns them into two
// digital sticks, one result per touch frame while enabled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one touch report or none plus
//   a frame-end mark. Output channel (out_valid / out_stall) carries one
//   transaction per frame-end item while enabled: four stick values and
//   their drive bits.
//   Each item is latched into an input register, from which the zone trackers
//   and the result register are updated. One item is taken every cycle while
//   in_stall is low.
//   When out_stall holds a waiting result, a frame-end item in the input
//   register waits and in_stall rises; items without a frame end still
//   flow through.
//   Reset clears the trackers and loads the register defaults (enabled, split
//   at 640, deadzone 12, reversal step 10, full scale 32767). Configuration
//   is written through the APB-style port while idle, kept so by the user alone.
// ----------------------------------------------------------------------------
module touch_slide_to_stick_core
	import tss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               touch_present,
	input  logic [10:0]        touch_x,
	input  logic [9:0]         touch_y,
	input  logic [31:0]        finger_id,
	input  logic               frame_end,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] left_x,
	output logic               left_x_drive,
	output logic signed [15:0] left_y,
	output logic               left_y_drive,
	output logic signed [15:0] right_x,
	output logic               right_x_drive,
	output logic signed [15:0] right_y,
	output logic               right_y_drive
);

	// configuration registers
	logic        enabled_q;
	logic [10:0] zone_split_x_q;
	logic [9:0]  deadzone_q;
	logic [9:0]  rev_min_step_q;
	logic [14:0] full_scale_q;

	// input register
	logic        valid_s1;
	logic        present_s1;
	logic [10:0] x_s1;
	logic [9:0]  y_s1;
	logic [31:0] id_s1;
	logic        fend_s1;

	// per-zone trackers, index 0 left, 1 right
	logic        active_q [2];
	logic [31:0] finger_q [2];
	logic [10:0] org_x_q  [2];
	logic [9:0]  org_y_q  [2];
	logic [10:0] last_x_q [2];
	logic [9:0]  last_y_q [2];
	dir_t        dir_x_q  [2];
	dir_t        dir_y_q  [2];
	logic        seen_q   [2];

	logic        active_d [2];
	logic [31:0] finger_d [2];
	logic [10:0] org_x_d  [2];
	logic [9:0]  org_y_d  [2];
	logic [10:0] last_x_d [2];
	logic [9:0]  last_y_d [2];
	dir_t        dir_x_d  [2];
	dir_t        dir_y_d  [2];
	logic        seen_d   [2];

	logic        out_valid_q;
	logic        produce;
	logic        proc;
	logic        side_s1;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	// returns {rebase, next direction} for one axis
	function automatic logic [2:0] axis_next(
		input dir_t              dir,
		input logic signed [11:0] total,
		input logic signed [11:0] step,
		input dir_t              target,
		input logic [9:0]        dz,
		input logic [9:0]        rms
	);
		logic [11:0] tmag;
		logic [11:0] smag;
		logic [2:0]  res;
		tmag = total[11] ? 12'(-total) : 12'(total);
		smag = step[11] ? 12'(-step) : 12'(step);
		res  = {1'b0, dir};
		if (tmag >= {2'b00, dz}) begin
			if (dir != DIR_NEUTRAL && target != dir && smag >= {2'b00, rms}) begin
				res = {1'b1, DIR_NEUTRAL};
			end else begin
				res = {1'b0, target};
			end
		end
		return res;
	endfunction

	function automatic logic [15:0] stick_val(input dir_t dir, input logic [14:0] fs);
		logic [15:0] v;
		v = '0;
		if (dir == DIR_POS) begin
			v = {1'b0, fs};
		end else if (dir == DIR_NEG) begin
			v = 16'(-{1'b0, fs});
		end
		return v;
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_ENABLED:      prdata = {31'd0, enabled_q};
			REG_ZONE_SPLIT_X: prdata = {21'd0, zone_split_x_q};
			REG_DEADZONE:     prdata = {22'd0, deadzone_q};
			REG_REV_MIN_STEP: prdata = {22'd0, rev_min_step_q};
			REG_FULL_SCALE:   prdata = {17'd0, full_scale_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= RST_ENABLED;
			zone_split_x_q <= RST_ZONE_SPLIT_X;
			deadzone_q     <= RST_DEADZONE;
			rev_min_step_q <= RST_REV_MIN_STEP;
			full_scale_q   <= RST_FULL_SCALE;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ENABLED:      enabled_q      <= pwdata[0];
				REG_ZONE_SPLIT_X: zone_split_x_q <= pwdata[10:0];
				REG_DEADZONE:     deadzone_q     <= pwdata[9:0];
				REG_REV_MIN_STEP: rev_min_step_q <= pwdata[9:0];
				REG_FULL_SCALE:   full_scale_q   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// handshake: a frame-end item waits for room in the result register while enabled
	assign produce  = enabled_q && fend_s1;
	assign proc     = valid_s1 && (!produce || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proc;
	assign side_s1  = (x_s1 < zone_split_x_q) ? 1'b0 : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			present_s1 <= touch_present;
			x_s1       <= touch_x;
			y_s1       <= touch_y;
			id_s1      <= finger_id;
			fend_s1    <= frame_end;
		end
	end

	// tracker update
	always_comb begin
		logic signed [11:0] tx;
		logic signed [11:0] mx;
		logic signed [10:0] ty;
		logic signed [10:0] my;
		logic [2:0]         ax;
		logic [2:0]         ay;
		for (int k = 0; k < 2; k++) begin
			active_d[k] = active_q[k];
			finger_d[k] = finger_q[k];
			org_x_d[k]  = org_x_q[k];
			org_y_d[k]  = org_y_q[k];
			last_x_d[k] = last_x_q[k];
			last_y_d[k] = last_y_q[k];
			dir_x_d[k]  = dir_x_q[k];
			dir_y_d[k]  = dir_y_q[k];
			seen_d[k]   = seen_q[k];

			tx = 12'({1'b0, x_s1}) - 12'({1'b0, org_x_q[k]});
			mx = 12'({1'b0, x_s1}) - 12'({1'b0, last_x_q[k]});
			ty = 11'({1'b0, y_s1}) - 11'({1'b0, org_y_q[k]});
			my = 11'({1'b0, y_s1}) - 11'({1'b0, last_y_q[k]});
			ax = axis_next(dir_x_q[k], tx, mx, (tx > 12'sd0) ? DIR_POS : DIR_NEG,
				deadzone_q, rev_min_step_q);
			ay = axis_next(dir_y_q[k], 12'(ty), 12'(my), (ty < 11'sd0) ? DIR_POS : DIR_NEG,
				deadzone_q, rev_min_step_q);

			if (proc && enabled_q && present_s1 && side_s1 == k[0] && !seen_q[k]) begin
				seen_d[k]   = 1'b1;
				last_x_d[k] = x_s1;
				last_y_d[k] = y_s1;
				if (!active_q[k] || finger_q[k] != id_s1) begin
					// new finger: start over at this point
					active_d[k] = 1'b1;
					finger_d[k] = id_s1;
					org_x_d[k]  = x_s1;
					org_y_d[k]  = y_s1;
					dir_x_d[k]  = DIR_NEUTRAL;
					dir_y_d[k]  = DIR_NEUTRAL;
				end else begin
					dir_x_d[k] = ax[1:0];
					dir_y_d[k] = ay[1:0];
					if (ax[2]) begin
						org_x_d[k] = x_s1;
					end
					if (ay[2]) begin
						org_y_d[k] = y_s1;
					end
				end
			end

			if (proc && produce) begin
				if (!seen_d[k]) begin
					active_d[k] = 1'b0;
					dir_x_d[k]  = DIR_NEUTRAL;
					dir_y_d[k]  = DIR_NEUTRAL;
				end
				seen_d[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				active_q[k] <= 1'b0;
				finger_q[k] <= '0;
				org_x_q[k]  <= '0;
				org_y_q[k]  <= '0;
				last_x_q[k] <= '0;
				last_y_q[k] <= '0;
				dir_x_q[k]  <= DIR_NEUTRAL;
				dir_y_q[k]  <= DIR_NEUTRAL;
				seen_q[k]   <= 1'b0;
			end
		end else begin
			for (int k = 0; k < 2; k++) begin
				active_q[k] <= active_d[k];
				finger_q[k] <= finger_d[k];
				org_x_q[k]  <= org_x_d[k];
				org_y_q[k]  <= org_y_d[k];
				last_x_q[k] <= last_x_d[k];
				last_y_q[k] <= last_y_d[k];
				dir_x_q[k]  <= dir_x_d[k];
				dir_y_q[k]  <= dir_y_d[k];
				seen_q[k]   <= seen_d[k];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && produce) begin
			left_x_drive  <= active_d[0] && dir_x_d[0] != DIR_NEUTRAL;
			left_y_drive  <= active_d[0] && dir_y_d[0] != DIR_NEUTRAL;
			right_x_drive <= active_d[1] && dir_x_d[1] != DIR_NEUTRAL;
			right_y_drive <= active_d[1] && dir_y_d[1] != DIR_NEUTRAL;
			left_x  <= active_d[0] ? stick_val(dir_x_d[0], full_scale_q) : '0;
			left_y  <= active_d[0] ? stick_val(dir_y_d[0], full_scale_q) : '0;
			right_x <= active_d[1] ? stick_val(dir_x_d[1], full_scale_q) : '0;
			right_y <= active_d[1] ? stick_val(dir_y_d[1], full_scale_q) : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
